/* design/mapped_led_shift_register_driver_top_defines.svh */
// Assertion macros used by the top-level design file.
`ifndef MAPPED_LED_SHIFT_REGISTER_DRIVER_TOP_DEFINES_SVH
`define MAPPED_LED_SHIFT_REGISTER_DRIVER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MLSRD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MLSRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/mlsrd_pkg.sv */
`timescale 1ns / 1ps
package mlsrd_pkg;

    localparam int MAX_BITS_DEF = 64;
    localparam int MAX_LEDS_DEF = 64;

    localparam int LED_W = 6;
    localparam int POS_W = 6;
    localparam int CFG_W = 7;
    localparam int REQ_W = 3;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd8;

    typedef enum logic [REQ_W-1:0] {
        REQ_MAP   = 3'd0,
        REQ_ON    = 3'd1,
        REQ_OFF   = 3'd2,
        REQ_CLEAR = 3'd3,
        REQ_FLUSH = 3'd4
    } req_t;

    typedef struct packed {
        logic             en;
        logic             valid;
        logic [LED_W-1:0] led;
        logic [POS_W-1:0] pos;
    } map_wr_t;

    typedef struct packed {
        logic             ok;
        logic [POS_W-1:0] pos;
    } map_rd_t;

endpackage

/* design/mlsrd_map.sv */
`timescale 1ns / 1ps
module mlsrd_map #(
    parameter int MAX_LEDS = mlsrd_pkg::MAX_LEDS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mlsrd_pkg::map_wr_t          wr,
    input  logic [mlsrd_pkg::LED_W-1:0] rd_led,
    output mlsrd_pkg::map_rd_t          rd
);
    import mlsrd_pkg::*;

    localparam int AW    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int IDX_W = ((AW > LED_W) ? AW : LED_W) + 1;

    logic [POS_W-1:0] pos_mem [MAX_LEDS];
    logic [MAX_LEDS-1:0] ok_bits_reg;
    logic             rd_ok_reg;
    logic [POS_W-1:0] rd_pos_reg;

    logic [IDX_W-1:0] wr_ext;
    logic [IDX_W-1:0] rd_ext;
    logic             wr_in_range;
    logic             rd_in_range;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;

    assign wr_ext      = IDX_W'(wr.led);
    assign rd_ext      = IDX_W'(rd_led);
    assign wr_in_range = wr_ext < IDX_W'(MAX_LEDS);
    assign rd_in_range = rd_ext < IDX_W'(MAX_LEDS);
    assign wr_addr     = wr_ext[AW-1:0];
    assign rd_addr     = rd_ext[AW-1:0];

    always_ff @(posedge aclk) begin
        if (wr.en && wr_in_range) begin
            pos_mem[wr_addr] <= wr.pos;
        end
        rd_pos_reg <= pos_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ok_bits_reg <= '0;
            rd_ok_reg   <= 1'b0;
        end else begin
            if (wr.en && wr_in_range) begin
                ok_bits_reg[wr_addr] <= wr.valid;
            end
            rd_ok_reg <= rd_in_range && ok_bits_reg[rd_addr];
        end
    end

    assign rd.ok  = rd_ok_reg;
    assign rd.pos = rd_pos_reg;

endmodule

/* design/mapped_led_shift_register_driver_top.sv */
`timescale 1ns / 1ps
// Drives a chained serial-in, parallel-out LED register. A map load (tuser 0) writes the
// LED-to-bit table; on (1) and off (2) pass through a lookup state for the synchronous
// table read before the image bit changes, and are dropped for an unmapped LED.
// Clear (3) zeroes the chained bits. Flush (4), and on, off or clear with buffered low,
// then shift out the image as one word per chained bit (bits_in_use, clamped to
// 1..MAX_BITS), highest bit first, tlast on the latch bit, so such a request occupies
// the block while the shift counter runs, and longer while a waiting word sees m_tready
// low; the output register lets the next request enter while the final bit waits. The
// table's valid flags clear at reset, with no clearing pass.
module mapped_led_shift_register_driver_top #(
    parameter int MAX_BITS = mlsrd_pkg::MAX_BITS_DEF,
    parameter int MAX_LEDS = mlsrd_pkg::MAX_LEDS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [mlsrd_pkg::CFG_W-1:0] cfg_wr_data,  // bits_in_use
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // led_index [5:0], bit_position [11:6], map_valid [12], buffered [13]
    input  logic [15:0]                 s_tdata,
    input  logic [mlsrd_pkg::REQ_W-1:0] s_tuser,      // req_type [2:0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,      // serial_bit [0]
    output logic                        m_tlast       // latch_last
);
    import mlsrd_pkg::*;
    `include "mapped_led_shift_register_driver_top_defines.svh"

    localparam int CW = $clog2(MAX_BITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SHIFT
    } state_t;

    state_t           state_reg;
    logic [CFG_W-1:0] cfg_reg;
    logic [MAX_BITS-1:0] image_reg;
    logic [CW-1:0]    cnt_reg;
    logic             is_on_reg;
    logic             buffered_reg;
    logic             m_tvalid_reg;
    logic             m_bit_reg;
    logic             m_last_reg;

    logic [LED_W-1:0] in_led;
    logic [POS_W-1:0] in_pos;
    logic             in_valid;
    logic             in_buffered;
    req_t             in_req;
    logic             accept;
    logic             out_load;
    logic [CW-1:0]    len_m1;
    logic [MAX_BITS-1:0] clear_mask;
    logic             pos_fits;
    map_wr_t          map_wr;
    map_rd_t          map_rd;

    assign in_led      = s_tdata[5:0];
    assign in_pos      = s_tdata[11:6];
    assign in_valid    = s_tdata[12];
    assign in_buffered = s_tdata[13];
    assign in_req      = req_t'(s_tuser);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = !m_tvalid_reg || m_tready;

    always_comb begin
        if (cfg_reg == '0) begin
            len_m1 = '0;
        end else if (cfg_reg > CFG_W'(MAX_BITS)) begin
            len_m1 = CW'(MAX_BITS - 1);
        end else begin
            len_m1 = CW'(cfg_reg - CFG_W'(1));
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_BITS; i++) begin
            clear_mask[i] = (CW'(i) <= len_m1);
        end
    end

    assign pos_fits = {1'b0, map_rd.pos} < (POS_W + 1)'(MAX_BITS);

    assign map_wr.en    = accept && (in_req == REQ_MAP);
    assign map_wr.valid = in_valid;
    assign map_wr.led   = in_led;
    assign map_wr.pos   = in_pos;

    mlsrd_map #(
        .MAX_LEDS(MAX_LEDS)
    ) u_map (
        .aclk   (aclk),
        .aresetn(aresetn),
        .wr     (map_wr),
        .rd_led (in_led),
        .rd     (map_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cfg_reg      <= CFG_RESET;
            image_reg    <= '0;
            cnt_reg      <= '0;
            is_on_reg    <= 1'b0;
            buffered_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_bit_reg    <= 1'b0;
            m_last_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
            if (m_tready && (state_reg != ST_SHIFT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        cnt_reg      <= len_m1;
                        buffered_reg <= in_buffered;
                        is_on_reg    <= (in_req == REQ_ON);
                        case (in_req)
                            REQ_ON, REQ_OFF: begin
                                state_reg <= ST_LOOKUP;
                            end
                            REQ_CLEAR: begin
                                image_reg <= image_reg & ~clear_mask;
                                if (!in_buffered) begin
                                    state_reg <= ST_SHIFT;
                                end
                            end
                            REQ_FLUSH: begin
                                state_reg <= ST_SHIFT;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_LOOKUP: begin
                    if (map_rd.ok && pos_fits) begin
                        image_reg[map_rd.pos[CW-1:0]] <= is_on_reg;
                        state_reg <= buffered_reg ? ST_IDLE : ST_SHIFT;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_SHIFT: begin
                    if (out_load) begin
                        m_tvalid_reg <= 1'b1;
                        m_bit_reg    <= image_reg[cnt_reg];
                        m_last_reg   <= (cnt_reg == '0);
                        if (cnt_reg == '0) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            cnt_reg <= cnt_reg - CW'(1);
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, m_bit_reg};
    assign m_tlast  = m_last_reg;

    `MLSRD_ASSERT_NEXT(a_last_ends_shift,
        (state_reg == ST_SHIFT) && out_load && (cnt_reg == '0),
        m_tvalid && m_tlast && (state_reg == ST_IDLE),
        "final shift word must carry tlast and end the shift")
    `MLSRD_ASSERT_NEXT(a_flush_shifts,
        accept && (in_req == REQ_FLUSH),
        (state_reg == ST_SHIFT) && (cnt_reg == $past(len_m1)),
        "flush must start a shift of the full chain")
    `MLSRD_ASSERT_NEXT(a_lookup_one_cycle,
        state_reg == ST_LOOKUP,
        state_reg != ST_LOOKUP,
        "table lookup must last one cycle")
    `MLSRD_ASSERT_NOW(a_mid_shift_no_tlast,
        (state_reg == ST_SHIFT) && m_tvalid && (cnt_reg != len_m1),
        !m_tlast,
        "tlast shown before the shift finished")

endmodule

/* tb/mapped_led_shift_register_driver_top_tb.sv */
`timescale 1ns / 1ps
module mapped_led_shift_register_driver_top_tb;
    import mlsrd_pkg::*;

    localparam int IMAGE_BITS    = MAX_BITS_DEF;
    localparam int TABLE_LEDS    = MAX_LEDS_DEF;
    localparam int SETTLE_CYCLES = IMAGE_BITS + 16;
    localparam int QUIET_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 48;
    localparam logic [REQ_W-1:0] REQ_CODE_MAX = '1;

    typedef struct packed {
        logic [REQ_W-1:0] kind;
        logic [LED_W-1:0] led;
        logic [POS_W-1:0] pos;
        logic             map_valid;
        logic             hold;
    } led_req_t;

    typedef struct packed {
        logic serial;
        logic latch;
    } shift_bit_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]  cfg_wr_data = CFG_RESET;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata = '0;
    logic [REQ_W-1:0]  s_tuser = REQ_FLUSH;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;
    logic              m_tlast;

    led_req_t          pending_reqs[$];
    shift_bit_t        bits_due[$];
    led_req_t          sent_req;
    led_req_t          seen_req;
    shift_bit_t        due_bit;

    logic [IMAGE_BITS-1:0] image_bits = '0;
    bit                    map_on [TABLE_LEDS];
    logic [POS_W-1:0]      map_at [TABLE_LEDS];
    logic [CFG_W-1:0]      chain_cfg = CFG_RESET;

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int fault_count     = 0;
    int quiet_cycles    = 0;

    mapped_led_shift_register_driver_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic int chain_len(input logic [CFG_W-1:0] cfg);
        if (cfg < 1) return 1;
        if (cfg > IMAGE_BITS) return IMAGE_BITS;
        return int'(cfg);
    endfunction

    function automatic led_req_t req_word(input int kind, input int led,
                                          input int pos, input int map_valid, input int hold);
        led_req_t r;
        r.kind      = kind[REQ_W-1:0];
        r.led       = led[LED_W-1:0];
        r.pos       = pos[POS_W-1:0];
        r.map_valid = map_valid[0];
        r.hold      = hold[0];
        return r;
    endfunction

    function automatic led_req_t random_req(input int len);
        int       pick;
        led_req_t r;
        pick = $urandom_range(0, 99);
        if (pick < 28)      r.kind = REQ_MAP;
        else if (pick < 53) r.kind = REQ_ON;
        else if (pick < 73) r.kind = REQ_OFF;
        else if (pick < 81) r.kind = REQ_CLEAR;
        else if (pick < 93) r.kind = REQ_FLUSH;
        else r.kind = REQ_W'($urandom_range(int'(REQ_FLUSH) + 1, int'(REQ_CODE_MAX)));
        r.led = ($urandom_range(0, 99) < 75) ? LED_W'($urandom_range(0, 7))
                                            : LED_W'($urandom_range(0, 63));
        r.pos = ($urandom_range(0, 99) < 70) ? POS_W'($urandom_range(0, len - 1))
                                            : POS_W'($urandom_range(0, 63));
        r.map_valid = $urandom_range(0, 99) < 85;
        r.hold      = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic queue_image_shift();
        int n;
        n = chain_len(chain_cfg);
        for (int k = 0; k < n; k++) begin
            bits_due.push_back('{serial: image_bits[n - 1 - k], latch: (k == n - 1)});
        end
    endtask

    task automatic predict_request(input led_req_t r);
        int n;
        case (r.kind)
            REQ_MAP: begin
                map_on[r.led] = r.map_valid;
                map_at[r.led] = r.map_valid ? r.pos : '0;
            end
            REQ_ON, REQ_OFF: begin
                if (map_on[r.led]) begin
                    image_bits[map_at[r.led]] = (r.kind == REQ_ON);
                    if (!r.hold) queue_image_shift();
                end
            end
            REQ_CLEAR: begin
                n = chain_len(chain_cfg);
                for (int i = 0; i < n; i++) image_bits[i] = 1'b0;
                if (!r.hold) queue_image_shift();
            end
            REQ_FLUSH: queue_image_shift();
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || s_tvalid || bits_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_chain_len(input logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        chain_cfg   <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                sent_req = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, sent_req.hold, sent_req.map_valid, sent_req.pos,
                             sent_req.led};
                s_tuser  <= sent_req.kind;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= $urandom_range(0, 99) >= recv_stall_pct;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (bits_due.size() == 0) begin
                    if (fault_count < 10)
                        $display("unexpected word: serial %0b latch %0b", m_tdata[0], m_tlast);
                    fault_count++;
                end else begin
                    due_bit = bits_due.pop_front();
                    if (m_tdata[0] !== due_bit.serial || m_tlast !== due_bit.latch) begin
                        if (fault_count < 10)
                            $display("mismatch: serial exp %0b got %0b, latch exp %0b got %0b",
                                     due_bit.serial, m_tdata[0], due_bit.latch, m_tlast);
                        fault_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                seen_req.kind      = s_tuser;
                seen_req.led       = s_tdata[5:0];
                seen_req.pos       = s_tdata[11:6];
                seen_req.map_valid = s_tdata[12];
                seen_req.hold      = s_tdata[13];
                predict_request(seen_req);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles + 1 >= QUIET_LIMIT) begin
                    $display("mapped_led_shift_register_driver_top_tb NOT OK");
                    $finish;
                end
            end
        end
    end

    initial begin
        logic [CFG_W-1:0] phase_cfg [6];
        for (int i = 0; i < TABLE_LEDS; i++) begin
            map_on[i] = 1'b0;
            map_at[i] = '0;
        end
        phase_cfg = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd8, 7'd33};
        phase_cfg[4] = CFG_W'($urandom_range(2, 63));
        sender_idle_pct = 26;
        recv_stall_pct  = 60;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed pass at the reset chain length
        pending_reqs.push_back(req_word(REQ_FLUSH, 0, 0, 0, 0));
        pending_reqs.push_back(req_word(REQ_ON, 0, 0, 1, 0));
        pending_reqs.push_back(req_word(REQ_MAP, 0, 7, 1, 0));
        pending_reqs.push_back(req_word(REQ_MAP, 63, 0, 1, 1));
        pending_reqs.push_back(req_word(REQ_MAP, 5, 63, 1, 0));
        pending_reqs.push_back(req_word(REQ_ON, 0, 63, 0, 0));
        pending_reqs.push_back(req_word(REQ_ON, 63, 0, 1, 1));
        pending_reqs.push_back(req_word(REQ_ON, 5, 0, 0, 0));
        pending_reqs.push_back(req_word(REQ_FLUSH, 63, 63, 1, 1));
        pending_reqs.push_back(req_word(REQ_OFF, 0, 0, 0, 0));
        pending_reqs.push_back(req_word(REQ_CLEAR, 0, 0, 0, 1));
        pending_reqs.push_back(req_word(REQ_FLUSH, 0, 0, 0, 0));
        pending_reqs.push_back(req_word(REQ_MAP, 5, 63, 0, 1));
        pending_reqs.push_back(req_word(REQ_OFF, 5, 0, 0, 0));
        for (int c = int'(REQ_FLUSH) + 1; c <= int'(REQ_CODE_MAX); c++)
            pending_reqs.push_back(req_word(c, 63, 63, 1, 0));
        pending_reqs.push_back(req_word(REQ_MAP, 42, 3, 1, 0));
        pending_reqs.push_back(req_word(REQ_ON, 42, 0, 0, 0));
        pending_reqs.push_back(req_word(REQ_ON, 63, 0, 0, 0));
        pending_reqs.push_back(req_word(REQ_CLEAR, 0, 0, 0, 0));
        pending_reqs.push_back(req_word(REQ_OFF, 42, 0, 0, 1));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            sender_idle_pct = (ph < 2) ? 26 : (ph < 4) ? 60 : 0;
            recv_stall_pct  = (ph < 2) ? 60 : (ph < 4) ? 26 : 0;
            write_chain_len(phase_cfg[ph]);
            for (int i = 0; i < PHASE_ITEMS; i++)
                pending_reqs.push_back(random_req(chain_len(phase_cfg[ph])));
            drain();
        end

        if (fault_count == 0 && bits_due.size() == 0) begin
            $display("mapped_led_shift_register_driver_top_tb OK");
        end else begin
            $display("mapped_led_shift_register_driver_top_tb NOT OK");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+design
design/mlsrd_pkg.sv
design/mlsrd_map.sv
design/mapped_led_shift_register_driver_top.sv
tb/mapped_led_shift_register_driver_top_tb.sv
